// File: rtl/pida_pkg.sv
// pida_pkg: shared types and constants for the positional insert/delete array
// transfer structs, op and status codes, cell control bundle, sequencer states
// no dependencies
package pida_pkg;

  localparam int DEPTH_DEF     = 128;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } pida_op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } pida_status_t;

  typedef enum logic {
    PIDA_IDLE,
    PIDA_SCAN
  } pida_state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         position;
    logic signed [31:0] value;
  } pida_cmd_t;

  typedef struct packed {
    logic signed [31:0] word;
    logic [7:0]         count;
    logic [1:0]         status;
  } pida_rsp_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic app;
    logic snap;
    logic shift;
  } pida_ctl_t;

endpackage

// File: rtl/pida_cell.sv
// pida_cell: one storage cell of the array chain plus one stage of the read chain
// takes words from its left or right neighbor on insert or delete
// depends on pida_pkg
module pida_cell #(
  parameter int WORD_BITS = pida_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = 8,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  pida_pkg::pida_ctl_t  ctl,
  input  logic [CNT_W-1:0]     pos,
  input  logic [CNT_W-1:0]     cnt,
  input  logic [WORD_BITS-1:0] value,
  input  logic [WORD_BITS-1:0] left_data,
  input  logic [WORD_BITS-1:0] right_data,
  input  logic [WORD_BITS-1:0] right_rd,
  output logic [WORD_BITS-1:0] data,
  output logic [WORD_BITS-1:0] rd
);

  localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_UP = CNT_W'(INDEX + 1);

  logic [WORD_BITS-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (IDX == pos) begin
        data_next = value;
      end else if (IDX > pos && IDX <= cnt) begin
        data_next = left_data;
      end
    end else if (ctl.del) begin
      if (IDX >= pos && IDX_UP < cnt) begin
        data_next = right_data;
      end
    end else if (ctl.app) begin
      if (IDX == cnt) begin
        data_next = value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // read chain: snapshot, then move toward cell zero
  always_ff @(posedge clk) begin
    if (ctl.snap) begin
      rd <= data;
    end else if (ctl.shift) begin
      rd <= right_rd;
    end
  end

endmodule

// File: rtl/pida_cell_row.sv
// pida_cell_row: the chain of DEPTH cells wired to their neighbors
// holds the stored words and the read chain that ends at cell zero
// depends on pida_pkg and pida_cell
module pida_cell_row #(
  parameter int DEPTH     = pida_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pida_pkg::WORD_BITS_DEF,
  parameter int CNT_W     = 8
) (
  input  logic                 clk,
  input  pida_pkg::pida_ctl_t  ctl,
  input  logic [CNT_W-1:0]     pos,
  input  logic [CNT_W-1:0]     cnt,
  input  logic [WORD_BITS-1:0] value,
  output logic [WORD_BITS-1:0] rd_head
);

  logic [WORD_BITS-1:0] data [DEPTH];
  logic [WORD_BITS-1:0] rd   [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    logic [WORD_BITS-1:0] right_rd_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w    = '0;
      assign right_rd_w = '0;
    end else begin : g_mid_r
      assign right_w    = data[g+1];
      assign right_rd_w = rd[g+1];
    end

    pida_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos),
      .cnt        (cnt),
      .value      (value),
      .left_data  (left_w),
      .right_data (right_w),
      .right_rd   (right_rd_w),
      .data       (data[g]),
      .rd         (rd[g])
    );
  end

  assign rd_head = rd[0];

endmodule

// File: rtl/positional_insert_delete_array_unit.sv
// positional_insert_delete_array_unit: top level, sequencer, count and result buffer
// depends on pida_pkg and pida_cell_row
// in-range read and delete are paced by the read chain, which moves the snapshot
// one cell per cycle toward cell zero; every other item emits when it is accepted
// throughput: one item per cycle, stalled while a scan runs or the skid slot is full
// reset: count zero, result buffer empty, stored words are not cleared
module positional_insert_delete_array_unit #(
  parameter int DEPTH     = pida_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pida_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pida_pkg::pida_cmd_t cmd,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output pida_pkg::pida_rsp_t rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  pida_pkg::pida_state_t state, state_next;
  pida_pkg::pida_ctl_t   ctl;
  pida_pkg::pida_rsp_t   emit_d;
  pida_pkg::pida_rsp_t   skid;

  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [CNT_W-1:0]     remain, remain_next;
  logic [CNT_W-1:0]     pos_n;
  logic [WORD_BITS-1:0] vword;
  logic [WORD_BITS-1:0] rd_head;
  logic [CMP_W-1:0]     pos_c, cnt_c;
  logic                 pos_lt_cnt, pos_le_cnt, full;
  logic                 accept, scan_start, emit;
  logic                 skid_valid, skid_valid_next, rsp_valid_next;

  assign pos_c      = CMP_W'(cmd.position);
  assign cnt_c      = CMP_W'(cnt);
  assign pos_lt_cnt = pos_c < cnt_c;
  assign pos_le_cnt = pos_c <= cnt_c;
  assign full       = cnt == CNT_W'(DEPTH);
  assign pos_n      = CNT_W'(cmd.position);
  assign vword      = WORD_BITS'($unsigned(cmd.value));

  assign cmd_stall  = (state != pida_pkg::PIDA_IDLE) || skid_valid;
  assign accept     = cmd_valid && !cmd_stall;
  assign scan_start = accept && pos_lt_cnt &&
                      (cmd.op == pida_pkg::OP_READ || cmd.op == pida_pkg::OP_DELETE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pida_pkg::PIDA_IDLE: begin
        if (scan_start) begin
          state_next = pida_pkg::PIDA_SCAN;
        end
      end
      pida_pkg::PIDA_SCAN: begin
        if (remain == '0) begin
          state_next = pida_pkg::PIDA_IDLE;
        end
      end
      default: state_next = pida_pkg::PIDA_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl         = '0;
    emit        = 1'b0;
    emit_d      = '0;
    cnt_next    = cnt;
    remain_next = remain;
    unique case (state)
      pida_pkg::PIDA_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          unique case (cmd.op)
            pida_pkg::OP_CLEAR: begin
              cnt_next = '0;
            end
            pida_pkg::OP_APPEND: begin
              if (full) begin
                emit_d.status = pida_pkg::STATUS_FULL;
              end else begin
                ctl.app  = 1'b1;
                cnt_next = cnt + 1'b1;
              end
            end
            pida_pkg::OP_READ: begin
              if (!pos_lt_cnt) begin
                emit_d.status = pida_pkg::STATUS_RANGE;
              end else begin
                emit        = 1'b0;
                ctl.snap    = 1'b1;
                remain_next = pos_n;
              end
            end
            pida_pkg::OP_INSERT: begin
              if (!pos_le_cnt) begin
                emit_d.status = pida_pkg::STATUS_RANGE;
              end else if (full) begin
                emit_d.status = pida_pkg::STATUS_FULL;
              end else begin
                ctl.ins  = 1'b1;
                cnt_next = cnt + 1'b1;
              end
            end
            pida_pkg::OP_DELETE: begin
              if (!pos_lt_cnt) begin
                emit_d.status = pida_pkg::STATUS_RANGE;
              end else begin
                emit        = 1'b0;
                ctl.snap    = 1'b1;
                ctl.del     = 1'b1;
                cnt_next    = cnt - 1'b1;
                remain_next = pos_n;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pida_pkg::PIDA_SCAN: begin
        if (remain == '0) begin
          emit        = 1'b1;
          emit_d.word = 32'(rd_head);
        end else begin
          ctl.shift   = 1'b1;
          remain_next = remain - 1'b1;
        end
      end
      default: begin
      end
    endcase
    emit_d.count = 8'(cnt_next);
  end

  pida_cell_row #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_row (
    .clk     (clk),
    .ctl     (ctl),
    .pos     (pos_n),
    .cnt     (cnt),
    .value   (vword),
    .rd_head (rd_head)
  );

  // result register with one skid slot
  always_comb begin
    rsp_valid_next  = rsp_valid;
    skid_valid_next = skid_valid;
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_valid_next  = 1'b1;
        skid_valid_next = emit;
      end else begin
        rsp_valid_next  = emit;
      end
    end else if (emit) begin
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp <= skid;
        if (emit) begin
          skid <= emit_d;
        end
      end else if (emit) begin
        rsp <= emit_d;
      end
    end else if (emit) begin
      skid <= emit_d;
    end
    remain <= remain_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pida_pkg::PIDA_IDLE;
      cnt        <= '0;
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      rsp_valid  <= rsp_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

endmodule
